// ===== rtl/lps_pkg.sv =====
// Package for the lamp pattern sequencer: field widths, parameter defaults and the
// command and status structures between controller and datapath. No dependencies.
package lps_pkg;

    localparam int LAMP_W          = 8;
    localparam int LED_INDEX_W     = 3;
    localparam int DURATION_W      = 16;
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_DUR_BITS    = 16;
    localparam logic [LAMP_W-1:0] ALL_ONES = 8'hff;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_PUSH = 1'b1;

    typedef struct packed {
        logic                   push;
        logic                   tick_start;
        logic                   rd_valid;
        logic [LED_INDEX_W-1:0] rd_ch;
        logic                   ap_valid;
        logic [LED_INDEX_W-1:0] ap_ch;
        logic                   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/lps_if.sv =====
// Valid/ready channel interfaces for lamp commands in and lamp bytes out.
// Depends on lps_pkg for the field widths.
interface lps_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [lps_pkg::LED_INDEX_W-1:0] led_index;
    logic                           on_off;
    logic [lps_pkg::DURATION_W-1:0] duration;
    logic                           first_of_run;

    modport source (output valid, func, led_index, on_off, duration, first_of_run,
                    input ready);
    modport sink (input valid, func, led_index, on_off, duration, first_of_run,
                  output ready);
endinterface

interface lps_out_if;
    logic                       valid;
    logic                       ready;
    logic [lps_pkg::LAMP_W-1:0] shift_byte;
    logic [lps_pkg::LAMP_W-1:0] busy_mask;
    logic                       overflow;

    modport source (output valid, shift_byte, busy_mask, overflow, input ready);
    modport sink (input valid, shift_byte, busy_mask, overflow, output ready);
endinterface

// ===== rtl/lps_ctrl.sv =====
// Controller of the lamp pattern sequencer: accepts transactions and sweeps the
// channels one per cycle on a tick. Depends on lps_pkg.
module lps_ctrl #(
    parameter int CHANNELS = lps_pkg::DEF_CHANNELS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_func,
    output logic             o_ready,
    output lps_pkg::t_dp_cmd o_cmd,
    input  lps_pkg::t_dp_sts i_sts
);
    import lps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TICK = 4'b0010,
        S_TAIL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [LED_INDEX_W-1:0] r_ch, n_ch;
    logic                   r_ap_valid, n_ap_valid;
    logic [LED_INDEX_W-1:0] r_ap_ch, n_ap_ch;
    logic                   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_ap_valid = 1'b0;
        n_ap_ch    = r_ap_ch;
        o_cmd      = '0;
        o_cmd.ap_valid = r_ap_valid;
        o_cmd.ap_ch    = r_ap_ch;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_PUSH) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_ch             = '0;
                        n_state          = S_TICK;
                    end
                end
            end
            S_TICK: begin
                o_cmd.rd_valid = 1'b1;
                o_cmd.rd_ch    = r_ch;
                n_ap_valid     = 1'b1;
                n_ap_ch        = r_ch;
                if (r_ch == LED_INDEX_W'(CHANNELS - 1)) begin
                    n_state = S_TAIL;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ch       <= '0;
            r_ap_valid <= 1'b0;
            r_ap_ch    <= '0;
        end else begin
            r_state    <= n_state;
            r_ch       <= n_ch;
            r_ap_valid <= n_ap_valid;
            r_ap_ch    <= n_ap_ch;
        end
    end

endmodule

// ===== rtl/lps_dp.sv =====
// Datapath of the lamp pattern sequencer: command store, per-channel queue state,
// countdowns, lamp bits and the result register. Depends on lps_pkg.
module lps_dp #(
    parameter int CHANNELS      = lps_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH   = lps_pkg::DEF_QUEUE_DEPTH,
    parameter int DURATION_BITS = lps_pkg::DEF_DUR_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lps_pkg::t_dp_cmd                  i_cmd,
    output lps_pkg::t_dp_sts                  o_sts,
    input  logic [lps_pkg::LED_INDEX_W-1:0]   i_led_index,
    input  logic                              i_on_off,
    input  logic [lps_pkg::DURATION_W-1:0]    i_duration,
    input  logic                              i_first_of_run,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lps_pkg::LAMP_W-1:0]        o_shift_byte,
    output logic [lps_pkg::LAMP_W-1:0]        o_busy_mask,
    output logic                              o_overflow
);
    import lps_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = DURATION_BITS + 1;

    logic [WORD_W-1:0]        mem [DEPTH];
    logic [WORD_W-1:0]        r_rd_data;

    logic [SLOT_W-1:0]        r_head  [CHANNELS];
    logic [SLOT_W-1:0]        n_head  [CHANNELS];
    logic [CNT_W-1:0]         r_count [CHANNELS];
    logic [CNT_W-1:0]         n_count [CHANNELS];
    logic [CHANNELS-1:0]      r_run, n_run;
    logic [DURATION_BITS-1:0] r_cd    [CHANNELS];
    logic [DURATION_BITS-1:0] n_cd    [CHANNELS];
    logic [CHANNELS-1:0]      r_lamp, n_lamp;
    logic                     r_ovf, n_ovf;

    logic                     r_out_valid;
    logic [LAMP_W-1:0]        r_out_shift;
    logic [LAMP_W-1:0]        r_out_busy;
    logic                     r_out_ovf;

    logic                     w_wr_en;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic [WORD_W-1:0]        w_wr_data;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic [CHANNELS-1:0]      w_busy;

    always_comb begin
        logic [SLOT_W-1:0] v_head;
        logic [CNT_W-1:0]  v_cnt;
        logic [SLOT_W:0]   v_sum;
        v_head    = '0;
        v_cnt     = '0;
        v_sum     = '0;
        n_head    = r_head;
        n_count   = r_count;
        n_run     = r_run;
        n_cd      = r_cd;
        n_lamp    = r_lamp;
        n_ovf     = r_ovf;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = {i_on_off, DURATION_BITS'(i_duration)};
        w_rd_addr = '0;
        if (i_cmd.tick_start || i_cmd.push) begin
            n_ovf = 1'b0;
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_cmd.push && (i_led_index == LED_INDEX_W'(i))) begin
                if (i_first_of_run) begin
                    v_head   = '0;
                    v_cnt    = '0;
                    n_run[i] = 1'b0;
                end else begin
                    v_head = r_head[i];
                    v_cnt  = r_count[i];
                end
                n_head[i]  = v_head;
                n_count[i] = v_cnt;
                if (v_cnt == CNT_W'(QUEUE_DEPTH)) begin
                    n_ovf = 1'b1;
                end else begin
                    v_sum = {1'b0, v_head} + (SLOT_W + 1)'(v_cnt);
                    if (v_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
                        v_sum = v_sum - (SLOT_W + 1)'(QUEUE_DEPTH);
                    end
                    w_wr_en    = 1'b1;
                    w_wr_addr  = ADDR_W'(i * QUEUE_DEPTH) + ADDR_W'(v_sum[SLOT_W-1:0]);
                    n_count[i] = v_cnt + 1'b1;
                end
            end
            if (i_cmd.rd_valid && (i_cmd.rd_ch == LED_INDEX_W'(i))) begin
                w_rd_addr = ADDR_W'(i * QUEUE_DEPTH) + ADDR_W'(r_head[i]);
            end
            if (i_cmd.ap_valid && (i_cmd.ap_ch == LED_INDEX_W'(i)) && (r_count[i] != '0)) begin
                if (!r_run[i]) begin
                    n_lamp[i] = r_rd_data[DURATION_BITS];
                    n_cd[i]   = r_rd_data[DURATION_BITS-1:0];
                    n_run[i]  = 1'b1;
                end else if (r_cd[i] == '0) begin
                    n_lamp[i]  = 1'b0;
                    n_head[i]  = (r_head[i] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_head[i] + 1'b1;
                    n_count[i] = r_count[i] - 1'b1;
                    n_run[i]   = 1'b0;
                end else begin
                    n_cd[i] = r_cd[i] - 1'b1;
                end
            end
            w_busy[i] = (r_count[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_valid) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_cd[i]    <= '0;
            end
            r_run       <= '0;
            r_lamp      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_cd    <= n_cd;
            r_run   <= n_run;
            r_lamp  <= n_lamp;
            r_ovf   <= n_ovf;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_shift <= ~LAMP_W'(r_lamp) & ALL_ONES;
            r_out_busy  <= LAMP_W'(w_busy);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_shift_byte   = r_out_shift;
    assign o_busy_mask    = r_out_busy;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== rtl/led_pattern_sequencer_core.sv =====
// Top level of the lamp pattern sequencer: joins controller and datapath to the
// channel interfaces. Depends on lps_pkg, lps_if, lps_ctrl and lps_dp.
//
//   Port      Direction  Transaction
//   i_cmd     in         tick or lamp command push (func, led_index, on_off, ...)
//   o_res     out        inverted lamp byte, busy mask and overflow flag
//
// After a push is accepted the queue is updated, and the result register is then
// loaded in the emit state before the next ready.
// A tick sweeps the channels: the command store has one read port, so the
// channels are read and advanced one per cycle, followed by a tail and a load.
// A result waiting in the output register stalls the load cycle only.
// Reset is synchronous and active low; it empties every queue and turns all lamps off.
module led_pattern_sequencer_core #(
    parameter int CHANNELS      = lps_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH   = lps_pkg::DEF_QUEUE_DEPTH,
    parameter int DURATION_BITS = lps_pkg::DEF_DUR_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_in_if.sink    i_cmd,
    lps_out_if.source o_res
);
    import lps_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    assign i_cmd.ready = w_ready;

    lps_ctrl #(
        .CHANNELS(CHANNELS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_func  (i_cmd.func),
        .o_ready (w_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    lps_dp #(
        .CHANNELS      (CHANNELS),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_led_index    (i_cmd.led_index),
        .i_on_off       (i_cmd.on_off),
        .i_duration     (i_cmd.duration),
        .i_first_of_run (i_cmd.first_of_run),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_shift_byte   (o_res.shift_byte),
        .o_busy_mask    (o_res.busy_mask),
        .o_overflow     (o_res.overflow)
    );

endmodule

// ===== rtl/lps_checker.sv =====
// Port-level checks for the lamp pattern sequencer, bound to the top level.
// Depends on lps_pkg and led_pattern_sequencer_core.
module lps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_func,
    input logic                        i_first_of_run,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [lps_pkg::LAMP_W-1:0]  i_shift_byte,
    input logic [lps_pkg::LAMP_W-1:0]  i_busy_mask,
    input logic                        i_overflow
);
    import lps_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted while the previous transaction was in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_shift_byte)
                                           && $stable(i_busy_mask) && $stable(i_overflow)))
        else $error("stalled result changed or vanished");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FUNC_PUSH)) ##1 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("push result not presented two cycles after acceptance");

    a_clear_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FUNC_PUSH) && i_first_of_run)
            ##1 (!i_out_valid || i_out_ready) |=> !i_overflow)
        else $error("clearing push reported an overflow");

endmodule

bind led_pattern_sequencer_core lps_checker u_lps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_func         (i_cmd.func),
    .i_first_of_run (i_cmd.first_of_run),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_shift_byte   (o_res.shift_byte),
    .i_busy_mask    (o_res.busy_mask),
    .i_overflow     (o_res.overflow)
);
